// File: hdl/lsgf_pkg.sv
// shared types and constants for the laser scan gap finder
// used by every module under hdl, no dependencies of its own
package lsgf_pkg;

  // scan geometry
  localparam int SECTORS            = 60;
  localparam int SAMPLES_PER_SECTOR = 3;
  localparam int SAMPLE_BITS        = 16;

  // fixed port and state widths
  localparam int DIST_W = 16;
  localparam int SECT_W = 6;
  localparam int THR_W  = 16;
  localparam int GAP_W  = 8;
  localparam int CFG_W  = 16;
  localparam int SPS_W  = $clog2(SAMPLES_PER_SECTOR + 1);

  localparam logic [DIST_W-1:0] SAMPLE_MASK =
    DIST_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  // steering constants
  localparam logic [SECT_W-1:0]  CENTER_SECTOR = SECT_W'(30);
  localparam logic signed [6:0]  DEAD_BAND     = 7'sd5;
  localparam logic [THR_W-1:0]   THR_RESET     = THR_W'(1000);
  localparam logic [GAP_W-1:0]   GAP_RESET     = GAP_W'(23);

  // queue between front and back
  localparam int EVQ_DEPTH = 4;
  localparam int EVQ_AW    = $clog2(EVQ_DEPTH);

  // result queue
  localparam int OQ_DEPTH = 2;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);

  // configuration register indexes
  localparam logic REG_CLEAR_THRESHOLD = 1'b0;
  localparam logic REG_MIN_GAP_DEGREES = 1'b1;

  // one event from the front: a finished sector and/or the end of a scan
  typedef struct packed {
    logic              last;
    logic              sec_done;
    logic              sec_clr;
    logic [DIST_W-1:0] sec_peak;
    logic [SECT_W-1:0] sec_idx;
  } evt_t;

  // head of the event queue as seen by the back
  typedef struct packed {
    logic empty;
    evt_t evt;
  } evq_head_t;

  // best gap of a finished scan
  typedef struct packed {
    logic              found;
    logic [SECT_W-1:0] start;
    logic [SECT_W-1:0] stop;
  } fin_t;

  // one result item
  typedef struct packed {
    logic                found;
    logic [SECT_W-1:0]   best_sector;
    logic                turn_needed;
    logic signed [7:0]   turn_amount;
  } res_t;

endpackage

// File: hdl/lsgf_front.sv
// front part: groups samples into sectors and emits sector and scan-end events
// depends on lsgf_pkg
module lsgf_front import lsgf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [DIST_W-1:0] distance,
  input  logic              scan_end,
  input  logic [THR_W-1:0]  clear_threshold,
  output logic              evt_push,
  output evt_t              evt
);

  logic [SPS_W-1:0]  cnt_r, cnt_nxt;
  logic [SECT_W-1:0] idx_r, idx_nxt;
  logic              full_r, full_nxt;
  logic              clr_r, clr_nxt;
  logic [DIST_W-1:0] peak_r, peak_nxt;

  logic [DIST_W-1:0] d;
  logic              clr_new;
  logic [DIST_W-1:0] peak_new;
  logic [SPS_W-1:0]  cnt_inc;
  logic              done;
  logic [SECT_W:0]   idx_inc;

  // sample classification
  always_comb begin
    d        = distance & SAMPLE_MASK;
    clr_new  = clr_r & (d > clear_threshold);
    peak_new = (d > peak_r) ? d : peak_r;
    cnt_inc  = cnt_r + SPS_W'(1);
    done     = !full_r && (cnt_inc == SPS_W'(SAMPLES_PER_SECTOR));
    idx_inc  = {1'b0, idx_r} + (SECT_W+1)'(1);
  end

  // sector accumulation
  always_comb begin
    cnt_nxt  = cnt_r;
    idx_nxt  = idx_r;
    full_nxt = full_r;
    clr_nxt  = clr_r;
    peak_nxt = peak_r;
    if (accept) begin
      if (!full_r) begin
        if (done) begin
          cnt_nxt  = '0;
          clr_nxt  = 1'b1;
          peak_nxt = '0;
          if (idx_inc >= (SECT_W+1)'(SECTORS)) begin
            full_nxt = 1'b1;
          end else begin
            idx_nxt = idx_inc[SECT_W-1:0];
          end
        end else begin
          cnt_nxt  = cnt_inc;
          clr_nxt  = clr_new;
          peak_nxt = peak_new;
        end
      end
      // scan end starts a fresh scan
      if (scan_end) begin
        cnt_nxt  = '0;
        idx_nxt  = '0;
        full_nxt = 1'b0;
        clr_nxt  = 1'b1;
        peak_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      idx_r  <= '0;
      full_r <= 1'b0;
      clr_r  <= 1'b1;
      peak_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      idx_r  <= idx_nxt;
      full_r <= full_nxt;
      clr_r  <= clr_nxt;
      peak_r <= peak_nxt;
    end
  end

  // event toward the back
  always_comb begin
    evt_push     = accept && (done || scan_end);
    evt.last     = scan_end;
    evt.sec_done = done;
    evt.sec_clr  = clr_new;
    evt.sec_peak = peak_new;
    evt.sec_idx  = idx_r;
  end

endmodule

// File: hdl/lsgf_evq.sv
// short queue of events between the front and the back
// depends on lsgf_pkg
module lsgf_evq import lsgf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  evt_t      push_evt,
  output logic      full,
  input  logic      pop,
  output evq_head_t head
);

  evt_t              mem [EVQ_DEPTH];
  logic [EVQ_AW-1:0] wp_r, wp_nxt;
  logic [EVQ_AW-1:0] rp_r, rp_nxt;
  logic [EVQ_AW:0]   cnt_r, cnt_nxt;

  // pointer and fill count
  always_comb begin
    wp_nxt  = push ? wp_r + EVQ_AW'(1) : wp_r;
    rp_nxt  = pop ? rp_r + EVQ_AW'(1) : rp_r;
    cnt_nxt = cnt_r + (EVQ_AW+1)'(push) - (EVQ_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_evt;
    end
  end

  always_comb begin
    full       = (cnt_r == (EVQ_AW+1)'(EVQ_DEPTH));
    head.empty = (cnt_r == '0);
    head.evt   = mem[rp_r];
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (EVQ_AW+1)'(EVQ_DEPTH))
    else $error("event queue over its depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !head.empty)
    else $error("event queue popped while empty");

  assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> !head.empty)
    else $error("event queue lost a transfer");

endmodule

// File: hdl/lsgf_back.sv
// back part: tracks gap runs and the best gap, then forms the steering result
// depends on lsgf_pkg
module lsgf_back import lsgf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  evq_head_t        head,
  output logic             pop,
  input  logic [GAP_W-1:0] min_gap_degrees,
  output logic             res_empty,
  input  logic             res_pop,
  output res_t             res
);

  // per-scan run and best-gap state
  logic              run_act_r, run_act_nxt;
  logic [SECT_W-1:0] run_start_r, run_start_nxt;
  logic [SECT_W-1:0] run_end_r, run_end_nxt;
  logic [DIST_W-1:0] run_peak_r, run_peak_nxt;
  logic              best_found_r, best_found_nxt;
  logic [DIST_W-1:0] best_peak_r, best_peak_nxt;
  logic [SECT_W-1:0] best_start_r, best_start_nxt;
  logic [SECT_W-1:0] best_end_r, best_end_nxt;

  // finished-scan stage
  fin_t              fin_r, fin_nxt;
  logic              fin_vld_r, fin_vld_nxt;
  logic              fin_adv;

  // result queue and held angle
  res_t              oq [OQ_DEPTH];
  logic [OQ_AW-1:0]  oq_wp_r, oq_rp_r;
  logic [OQ_AW:0]    oq_cnt_r;
  logic [SECT_W-1:0] held_r, held_nxt;

  // run update and close
  logic              ra1;
  logic [SECT_W-1:0] rs1, re1;
  logic [DIST_W-1:0] rp1;
  logic              close_en;
  logic [SECT_W:0]   run_len;
  logic [8:0]        run_deg;
  logic              take;

  // steering
  logic [SECT_W:0]   mid_sum;
  logic signed [6:0] diff;
  logic signed [7:0] diff8;
  logic              turn;
  res_t              res_new;

  evt_t              e;
  logic              ev_do;
  logic              oq_push;
  logic              oq_pop;

  // event acceptance: a scan end needs a free finish slot
  always_comb begin
    e       = head.evt;
    fin_adv = fin_vld_r && (oq_cnt_r != (OQ_AW+1)'(OQ_DEPTH));
    ev_do   = !head.empty && (!e.last || !fin_vld_r || fin_adv);
    pop     = ev_do;
  end

  // run state after the sector of this event
  always_comb begin
    ra1 = run_act_r;
    rs1 = run_start_r;
    re1 = run_end_r;
    rp1 = run_peak_r;
    if (e.sec_done) begin
      if (e.sec_clr) begin
        ra1 = 1'b1;
        re1 = e.sec_idx;
        if (!run_act_r) begin
          rs1 = e.sec_idx;
          rp1 = e.sec_peak;
        end else if (e.sec_peak > run_peak_r) begin
          rp1 = e.sec_peak;
        end
      end else begin
        ra1 = 1'b0;
      end
    end
    // a blocked sector or the scan end closes the open run
    close_en = (e.sec_done && !e.sec_clr && run_act_r) || (e.last && ra1);
    run_len  = {1'b0, re1} - {1'b0, rs1} + (SECT_W+1)'(1);
    run_deg  = 9'({2'b00, run_len}) + 9'({1'b0, run_len, 1'b0});
    take     = close_en && (run_deg > {1'b0, min_gap_degrees})
               && (!best_found_r || (rp1 > best_peak_r));
  end

  // per-scan state update
  always_comb begin
    run_act_nxt    = run_act_r;
    run_start_nxt  = run_start_r;
    run_end_nxt    = run_end_r;
    run_peak_nxt   = run_peak_r;
    best_found_nxt = best_found_r;
    best_peak_nxt  = best_peak_r;
    best_start_nxt = best_start_r;
    best_end_nxt   = best_end_r;
    fin_nxt        = fin_r;
    fin_vld_nxt    = fin_vld_r && !fin_adv;
    if (ev_do) begin
      run_act_nxt   = ra1 && !close_en;
      run_start_nxt = rs1;
      run_end_nxt   = re1;
      run_peak_nxt  = rp1;
      if (take) begin
        best_found_nxt = 1'b1;
        best_peak_nxt  = rp1;
        best_start_nxt = rs1;
        best_end_nxt   = re1;
      end
      if (e.last) begin
        fin_nxt.found  = best_found_nxt;
        fin_nxt.start  = best_start_nxt;
        fin_nxt.stop   = best_end_nxt;
        fin_vld_nxt    = 1'b1;
        run_act_nxt    = 1'b0;
        run_start_nxt  = '0;
        run_end_nxt    = '0;
        run_peak_nxt   = '0;
        best_found_nxt = 1'b0;
        best_peak_nxt  = '0;
        best_start_nxt = '0;
        best_end_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_act_r    <= 1'b0;
      run_start_r  <= '0;
      run_end_r    <= '0;
      run_peak_r   <= '0;
      best_found_r <= 1'b0;
      best_peak_r  <= '0;
      best_start_r <= '0;
      best_end_r   <= '0;
      fin_vld_r    <= 1'b0;
    end else begin
      run_act_r    <= run_act_nxt;
      run_start_r  <= run_start_nxt;
      run_end_r    <= run_end_nxt;
      run_peak_r   <= run_peak_nxt;
      best_found_r <= best_found_nxt;
      best_peak_r  <= best_peak_nxt;
      best_start_r <= best_start_nxt;
      best_end_r   <= best_end_nxt;
      fin_vld_r    <= fin_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    fin_r <= fin_nxt;
  end

  // midpoint and steering command
  always_comb begin
    mid_sum = {1'b0, fin_r.start} + {1'b0, fin_r.stop};
    held_nxt = held_r;
    if (fin_adv && fin_r.found) begin
      held_nxt = mid_sum[SECT_W:1];
    end
    diff  = 7'({1'b0, CENTER_SECTOR}) - 7'({1'b0, held_nxt});
    diff8 = 8'(diff);
    turn  = (diff > DEAD_BAND) || (diff < -DEAD_BAND);
    res_new.found       = fin_r.found;
    res_new.best_sector = held_nxt;
    res_new.turn_needed = turn;
    res_new.turn_amount = turn ? (diff8 + (diff8 <<< 1)) : 8'sd0;
  end

  // result queue control
  always_comb begin
    oq_push   = fin_adv;
    res_empty = (oq_cnt_r == '0);
    oq_pop    = res_pop && !res_empty;
    res       = oq[oq_rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= CENTER_SECTOR;
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      held_r   <= held_nxt;
      oq_wp_r  <= oq_push ? oq_wp_r + OQ_AW'(1) : oq_wp_r;
      oq_rp_r  <= oq_pop ? oq_rp_r + OQ_AW'(1) : oq_rp_r;
      oq_cnt_r <= oq_cnt_r + (OQ_AW+1)'(oq_push) - (OQ_AW+1)'(oq_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq[oq_wp_r] <= res_new;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    oq_cnt_r <= (OQ_AW+1)'(OQ_DEPTH))
    else $error("result queue over its depth");

  assert property (@(posedge clk) disable iff (!rst_n)
    (fin_vld_r && !fin_adv) |=> (fin_vld_r && $stable(fin_r)))
    else $error("finished scan overwritten before transfer");

  assert property (@(posedge clk) disable iff (!rst_n)
    best_found_r |-> (best_start_r <= best_end_r))
    else $error("best gap with start past end");

  assert property (@(posedge clk) disable iff (!rst_n)
    (!res_empty && !res.turn_needed) |-> (res.turn_amount == 8'sd0))
    else $error("turn amount set without a turn");

endmodule

// File: hdl/laser_scan_gap_finder_top.sv
// Laser scan gap finder, top level.
// Input queue side: one range sample per transfer (in_distance, in_scan_end);
// a sample is taken at a clock edge with in_push high and in_full low.
// Samples are grouped into sectors; sectors whose samples all exceed
// clear_threshold merge into gaps, and at the sample flagged in_scan_end the
// qualifying gap with the highest peak sample is reported as one result.
// Result queue side: out_empty low means a result is on the out_ ports; it
// is transferred at a clock edge with out_pop high.
// Throughput: one sample per clock while in_full is low; the front classifies
// samples and the back updates runs, each taking at most one event per cycle.
// Path of a result: the scan-end event goes through the event queue, the
// run/best update into the finish register, then steering into the result
// queue.
// When the receiver stalls, the two-entry result queue, the finish register
// and the four-entry event queue fill and in_full rises; nothing is dropped.
// Reset (rst_n low, synchronous) empties both queues, restores thresholds to
// 1000 mm and 23 degrees and the held angle to sector 30.
// Configuration: cfg_we writes cfg_wdata to register cfg_idx (0 threshold, 1
// minimum gap degrees); writes only while the block is idle, user-enforced.
module laser_scan_gap_finder_top import lsgf_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic [DIST_W-1:0]   in_distance,
  input  logic                in_scan_end,
  output logic                out_empty,
  input  logic                out_pop,
  output logic                out_found,
  output logic [SECT_W-1:0]   out_best_sector,
  output logic                out_turn_needed,
  output logic signed [7:0]   out_turn_amount,
  input  logic                cfg_we,
  input  logic                cfg_idx,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  logic [THR_W-1:0] thr_r, thr_nxt;
  logic [GAP_W-1:0] gap_r, gap_nxt;

  logic      accept;
  logic      evt_push;
  evt_t      evt;
  logic      evq_full;
  logic      evq_pop;
  evq_head_t evq_head;
  res_t      res;

  // configuration registers
  always_comb begin
    thr_nxt = thr_r;
    gap_nxt = gap_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        REG_CLEAR_THRESHOLD: thr_nxt = cfg_wdata[THR_W-1:0];
        REG_MIN_GAP_DEGREES: gap_nxt = cfg_wdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
      gap_r <= GAP_RESET;
    end else begin
      thr_r <= thr_nxt;
      gap_r <= gap_nxt;
    end
  end

  // input transfer
  assign in_full = evq_full;
  assign accept  = in_push && !evq_full;

  lsgf_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (accept),
    .distance        (in_distance),
    .scan_end        (in_scan_end),
    .clear_threshold (thr_r),
    .evt_push        (evt_push),
    .evt             (evt)
  );

  lsgf_evq u_evq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (evt_push),
    .push_evt (evt),
    .full     (evq_full),
    .pop      (evq_pop),
    .head     (evq_head)
  );

  lsgf_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (evq_head),
    .pop             (evq_pop),
    .min_gap_degrees (gap_r),
    .res_empty       (out_empty),
    .res_pop         (out_pop),
    .res             (res)
  );

  // result ports
  assign out_found       = res.found;
  assign out_best_sector = res.best_sector;
  assign out_turn_needed = res.turn_needed;
  assign out_turn_amount = res.turn_amount;

endmodule
